// ----- rtl/rc2c_pkg.sv -----
// Shared types, constants and rotate helpers for the 128-bit RC2-style cipher.
// Used by the channel interfaces, the sequencer, the step unit and the top level.
// No dependencies.
package rc2c_pkg;

  localparam int unsigned WORD_W       = 32;
  localparam int unsigned KEY_AW       = 8;
  localparam int unsigned SUBKEY_COUNT = 256;
  localparam int unsigned ROUND_COUNT  = 64;
  localparam int unsigned ROUND_W      = 6;

  localparam logic [ROUND_W-1:0] ROUND_LAST     = ROUND_W'(ROUND_COUNT - 1);
  localparam logic [1:0]         WORD_LAST      = 2'd3;
  localparam logic [2:0]         MOD6_LAST      = 3'd5;
  localparam logic [2:0]         MASH_ENC       = 3'd4;
  localparam logic [2:0]         MASH_DEC       = 3'd5;
  localparam logic [2:0]         DEC_START_MOD6 = 3'((ROUND_COUNT - 1) % 6);

  typedef enum logic [1:0] {
    CMD_LOAD = 2'd0,
    CMD_ENC  = 2'd1,
    CMD_DEC  = 2'd2
  } cmd_e;

  typedef logic [WORD_W-1:0] word_t;

  // Control bundle from the sequencer to the step unit and the result register.
  typedef struct packed {
    logic       load;
    logic       exec;
    logic       mash;
    logic       dec;
    logic [1:0] j;
    logic       fin;
  } ctrl_t;

  // Word j of the block rotates by 1, 2, 3 or 5.
  function automatic word_t rotl_word(word_t v, logic [1:0] j);
    word_t r;
    case (j)
      2'd0:    r = {v[30:0], v[31]};
      2'd1:    r = {v[29:0], v[31:30]};
      2'd2:    r = {v[28:0], v[31:29]};
      default: r = {v[26:0], v[31:27]};
    endcase
    return r;
  endfunction

  function automatic word_t rotr_word(word_t v, logic [1:0] j);
    word_t r;
    case (j)
      2'd0:    r = {v[0], v[31:1]};
      2'd1:    r = {v[1:0], v[31:2]};
      2'd2:    r = {v[2:0], v[31:3]};
      default: r = {v[4:0], v[31:5]};
    endcase
    return r;
  endfunction

endpackage

// ----- rtl/rc2c_if.sv -----
// Request and response channel interfaces of the RC2-style cipher.
// Depends on rc2c_pkg for the field widths.
interface rc2c_req_if;
  logic                                valid;
  logic                                ready;
  logic [1:0]                          cmd;
  logic [rc2c_pkg::KEY_AW-1:0]         key_index;
  logic [rc2c_pkg::WORD_W-1:0]         key_word;
  logic [rc2c_pkg::WORD_W-1:0]         block_word0;
  logic [rc2c_pkg::WORD_W-1:0]         block_word1;
  logic [rc2c_pkg::WORD_W-1:0]         block_word2;
  logic [rc2c_pkg::WORD_W-1:0]         block_word3;

  modport source (
    output valid, cmd, key_index, key_word,
           block_word0, block_word1, block_word2, block_word3,
    input  ready
  );
  modport sink (
    input  valid, cmd, key_index, key_word,
           block_word0, block_word1, block_word2, block_word3,
    output ready
  );
endinterface

interface rc2c_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [rc2c_pkg::WORD_W-1:0] out_word0;
  logic [rc2c_pkg::WORD_W-1:0] out_word1;
  logic [rc2c_pkg::WORD_W-1:0] out_word2;
  logic [rc2c_pkg::WORD_W-1:0] out_word3;
  logic                        was_decrypt;

  modport source (
    output valid, out_word0, out_word1, out_word2, out_word3, was_decrypt,
    input  ready
  );
  modport sink (
    input  valid, out_word0, out_word1, out_word2, out_word3, was_decrypt,
    output ready
  );
endinterface

// ----- rtl/rc2_style_128bit_block_cipher.sv -----
// 128-bit block cipher in the style of RC2, 64 rounds, 256-entry subkey table.
// Requests arrive on req_i (valid/ready); results leave on rsp_o (valid/ready).
// Depends on rc2c_pkg, rc2c_if, rc2c_key_ram, rc2c_step_unit and rc2c_ctrl.
//
// Usage:
//   cmd 0 writes key_word into subkey entry key_index and gives no
//   result. Every entry a block will use must be loaded first.
//   cmd 1 encrypts and cmd 2 decrypts block_word0..3; each gives one result
//   with was_decrypt set for a decryption. cmd 3 is taken and dropped.
//   A block request takes 296 word steps (256 mix steps and 40 mashing steps),
//   each one subkey read from the single table read port followed by one
//   update through the shared add/rotate unit. req_i.ready is low while a
//   block is being worked on, so the next request is taken only after the
//   result has been written to the output register.
//   The result sits in an output register; the block accepts the next request
//   while it waits. If a finished block finds that register still full, the
//   sequencer holds until the receiver takes the waiting result.
//   Reset clears the control state; the subkey table is not cleared.
module rc2_style_128bit_block_cipher (
  input  logic              clk_i,
  input  logic              rst_ni,
  rc2c_req_if.sink          req_i,
  rc2c_rsp_if.source        rsp_o
);

  logic                          idle;
  logic                          req_acc;
  logic                          key_we;
  logic                          start;
  logic                          start_dec;
  logic                          out_free;
  logic [rc2c_pkg::KEY_AW-1:0]   rd_addr;
  logic [rc2c_pkg::KEY_AW-1:0]   mash_addr;
  rc2c_pkg::word_t               key_rdata;
  rc2c_pkg::ctrl_t               ctrl;
  rc2c_pkg::word_t               res_word0, res_word1, res_word2, res_word3;

  logic                          out_valid_q;
  rc2c_pkg::word_t               out_word0_q, out_word1_q, out_word2_q, out_word3_q;
  logic                          was_decrypt_q;

  assign req_i.ready = idle;
  assign req_acc     = req_i.valid && idle;

  always_comb begin
    key_we    = 1'b0;
    start     = 1'b0;
    start_dec = 1'b0;
    unique case (rc2c_pkg::cmd_e'(req_i.cmd))
      rc2c_pkg::CMD_LOAD: key_we = req_acc;
      rc2c_pkg::CMD_ENC:  start  = req_acc;
      rc2c_pkg::CMD_DEC: begin
        start     = req_acc;
        start_dec = 1'b1;
      end
      default: begin
        key_we = 1'b0;
      end
    endcase
  end

  assign out_free = !out_valid_q || rsp_o.ready;

  rc2c_key_ram u_key_ram (
    .clk_i   (clk_i),
    .we_i    (key_we),
    .waddr_i (req_i.key_index),
    .wdata_i (req_i.key_word),
    .raddr_i (rd_addr),
    .rdata_o (key_rdata)
  );

  rc2c_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .start_dec_i (start_dec),
    .out_free_i  (out_free),
    .mash_addr_i (mash_addr),
    .idle_o      (idle),
    .rd_addr_o   (rd_addr),
    .ctrl_o      (ctrl)
  );

  rc2c_step_unit u_step_unit (
    .clk_i       (clk_i),
    .ctrl_i      (ctrl),
    .in_word0_i  (req_i.block_word0),
    .in_word1_i  (req_i.block_word1),
    .in_word2_i  (req_i.block_word2),
    .in_word3_i  (req_i.block_word3),
    .key_i       (key_rdata),
    .mash_addr_o (mash_addr),
    .res_word0_o (res_word0),
    .res_word1_o (res_word1),
    .res_word2_o (res_word2),
    .res_word3_o (res_word3)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl.fin) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.fin) begin
      out_word0_q   <= res_word0;
      out_word1_q   <= res_word1;
      out_word2_q   <= res_word2;
      out_word3_q   <= res_word3;
      was_decrypt_q <= ctrl.dec;
    end
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.out_word0   = out_word0_q;
  assign rsp_o.out_word1   = out_word1_q;
  assign rsp_o.out_word2   = out_word2_q;
  assign rsp_o.out_word3   = out_word3_q;
  assign rsp_o.was_decrypt = was_decrypt_q;

endmodule

// ----- rtl/rc2c_key_ram.sv -----
// Subkey table: 256 x 32 single-port-write, single-port-read memory.
// Read data is registered. Depends on rc2c_pkg.
module rc2c_key_ram (
  input  logic                         clk_i,
  input  logic                         we_i,
  input  logic [rc2c_pkg::KEY_AW-1:0]  waddr_i,
  input  rc2c_pkg::word_t              wdata_i,
  input  logic [rc2c_pkg::KEY_AW-1:0]  raddr_i,
  output rc2c_pkg::word_t              rdata_o
);

  rc2c_pkg::word_t mem_q [rc2c_pkg::SUBKEY_COUNT];
  rc2c_pkg::word_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/rc2c_step_unit.sv -----
// Shared mix/mash unit with the four block word registers.
// The words are kept rotated so that the word being updated is always slot 0.
// Depends on rc2c_pkg.
module rc2c_step_unit (
  input  logic                         clk_i,
  input  rc2c_pkg::ctrl_t              ctrl_i,
  input  rc2c_pkg::word_t              in_word0_i,
  input  rc2c_pkg::word_t              in_word1_i,
  input  rc2c_pkg::word_t              in_word2_i,
  input  rc2c_pkg::word_t              in_word3_i,
  input  rc2c_pkg::word_t              key_i,
  output logic [rc2c_pkg::KEY_AW-1:0]  mash_addr_o,
  output rc2c_pkg::word_t              res_word0_o,
  output rc2c_pkg::word_t              res_word1_o,
  output rc2c_pkg::word_t              res_word2_o,
  output rc2c_pkg::word_t              res_word3_o
);

  // Slot i holds block word (j + i) mod 4.
  rc2c_pkg::word_t slot_q [4];
  rc2c_pkg::word_t mix_f;
  rc2c_pkg::word_t new_word;

  assign mix_f = (slot_q[1] & ~slot_q[3]) + (slot_q[2] & slot_q[3]);

  always_comb begin
    if (ctrl_i.mash) begin
      new_word = ctrl_i.dec ? (slot_q[0] - key_i) : (slot_q[0] + key_i);
    end else if (ctrl_i.dec) begin
      new_word = rc2c_pkg::rotr_word(slot_q[0], ctrl_i.j) - (mix_f + key_i);
    end else begin
      new_word = rc2c_pkg::rotl_word(slot_q[0] + mix_f + key_i, ctrl_i.j);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      if (ctrl_i.dec) begin
        slot_q[0] <= in_word3_i;
        slot_q[1] <= in_word0_i;
        slot_q[2] <= in_word1_i;
        slot_q[3] <= in_word2_i;
      end else begin
        slot_q[0] <= in_word0_i;
        slot_q[1] <= in_word1_i;
        slot_q[2] <= in_word2_i;
        slot_q[3] <= in_word3_i;
      end
    end else if (ctrl_i.exec) begin
      // Encryption walks the words upward, decryption downward.
      if (ctrl_i.dec) begin
        slot_q[0] <= slot_q[3];
        slot_q[1] <= new_word;
        slot_q[2] <= slot_q[1];
        slot_q[3] <= slot_q[2];
      end else begin
        slot_q[0] <= slot_q[1];
        slot_q[1] <= slot_q[2];
        slot_q[2] <= slot_q[3];
        slot_q[3] <= new_word;
      end
    end
  end

  // The mashing subkey is picked by the low byte of the preceding word.
  assign mash_addr_o = slot_q[3][rc2c_pkg::KEY_AW-1:0];

  // After the last step the slots are aligned for encryption and offset by
  // one word for decryption.
  assign res_word0_o = ctrl_i.dec ? slot_q[1] : slot_q[0];
  assign res_word1_o = ctrl_i.dec ? slot_q[2] : slot_q[1];
  assign res_word2_o = ctrl_i.dec ? slot_q[3] : slot_q[2];
  assign res_word3_o = ctrl_i.dec ? slot_q[0] : slot_q[3];

endmodule

// ----- rtl/rc2c_ctrl.sv -----
// Round sequencer: walks the 64 rounds and 10 mashing rounds; each word step is a
// subkey read, then an update. Depends on rc2c_pkg.
module rc2c_ctrl (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic                         start_dec_i,
  input  logic                         out_free_i,
  input  logic [rc2c_pkg::KEY_AW-1:0]  mash_addr_i,
  output logic                         idle_o,
  output logic [rc2c_pkg::KEY_AW-1:0]  rd_addr_o,
  output rc2c_pkg::ctrl_t              ctrl_o
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_ADDR = 4'b0010,
    ST_EXEC = 4'b0100,
    ST_FIN  = 4'b1000
  } state_e;

  state_e                              state_q, state_d;
  logic [rc2c_pkg::ROUND_W-1:0]        r_q, r_d;
  logic [2:0]                          mod6_q, mod6_d;
  logic [1:0]                          j_q, j_d;
  logic                                mash_q, mash_d;
  logic                                dec_q, dec_d;

  logic step_end;
  logic mash_round;
  logic last_round;

  assign step_end   = (j_q == (dec_q ? 2'd0 : rc2c_pkg::WORD_LAST));
  assign mash_round = dec_q ? (mod6_q == rc2c_pkg::MASH_DEC)
                            : (mod6_q == rc2c_pkg::MASH_ENC);
  assign last_round = (r_q == (dec_q ? '0 : rc2c_pkg::ROUND_LAST));

  always_comb begin
    state_d = state_q;
    r_d     = r_q;
    mod6_d  = mod6_q;
    j_d     = j_q;
    mash_d  = mash_q;
    dec_d   = dec_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          state_d = ST_ADDR;
          dec_d   = start_dec_i;
          mash_d  = 1'b0;
          r_d     = start_dec_i ? rc2c_pkg::ROUND_LAST : '0;
          mod6_d  = start_dec_i ? rc2c_pkg::DEC_START_MOD6 : 3'd0;
          j_d     = start_dec_i ? rc2c_pkg::WORD_LAST : 2'd0;
        end
      end
      ST_ADDR: begin
        state_d = ST_EXEC;
      end
      ST_EXEC: begin
        state_d = ST_ADDR;
        if (!step_end) begin
          j_d = dec_q ? (j_q - 2'd1) : (j_q + 2'd1);
        end else if (!mash_q && mash_round) begin
          mash_d = 1'b1;
          j_d    = dec_q ? rc2c_pkg::WORD_LAST : 2'd0;
        end else if (last_round) begin
          state_d = ST_FIN;
        end else begin
          mash_d = 1'b0;
          j_d    = dec_q ? rc2c_pkg::WORD_LAST : 2'd0;
          if (dec_q) begin
            r_d    = r_q - 1'b1;
            mod6_d = (mod6_q == 3'd0) ? rc2c_pkg::MOD6_LAST : (mod6_q - 3'd1);
          end else begin
            r_d    = r_q + 1'b1;
            mod6_d = (mod6_q == rc2c_pkg::MOD6_LAST) ? 3'd0 : (mod6_q + 3'd1);
          end
        end
      end
      ST_FIN: begin
        if (out_free_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      r_q     <= '0;
      mod6_q  <= '0;
      j_q     <= '0;
      mash_q  <= 1'b0;
      dec_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      r_q     <= r_d;
      mod6_q  <= mod6_d;
      j_q     <= j_d;
      mash_q  <= mash_d;
      dec_q   <= dec_d;
    end
  end

  assign idle_o    = (state_q == ST_IDLE);
  assign rd_addr_o = mash_q ? mash_addr_i : {r_q, j_q};

  always_comb begin
    ctrl_o.load = (state_q == ST_IDLE) && start_i;
    ctrl_o.exec = (state_q == ST_EXEC);
    ctrl_o.mash = mash_q;
    ctrl_o.dec  = (state_q == ST_IDLE) ? start_dec_i : dec_q;
    ctrl_o.j    = j_q;
    ctrl_o.fin  = (state_q == ST_FIN) && out_free_i;
  end

  a_start_to_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE && start_i) |=> (state_q == ST_ADDR))
    else $error("block request did not start the round sequence");

  a_mash_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EXEC && mash_q) |->
      (dec_q ? (mod6_q == rc2c_pkg::MASH_DEC) : (mod6_q == rc2c_pkg::MASH_ENC)))
    else $error("mashing step outside a mashing round");

  a_fin_position: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FIN) |->
      (!mash_q && r_q == (dec_q ? '0 : rc2c_pkg::ROUND_LAST)
       && j_q == (dec_q ? 2'd0 : rc2c_pkg::WORD_LAST)))
    else $error("sequence finished before the last round step");

  a_exec_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EXEC) |=> (state_q == ST_ADDR || state_q == ST_FIN))
    else $error("update step not followed by a read or finish");

  a_mod6_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> (mod6_q <= rc2c_pkg::MOD6_LAST))
    else $error("round phase counter out of range");

endmodule

// ----- dv/rc2_style_128bit_block_cipher_test.sv -----
// Self-checking testbench for the 128-bit RC2-style block cipher: it loads subkeys,
// encrypts and decrypts blocks and checks every result against its own cipher model.
// Depends on rc2c_pkg, the rc2c_req_if/rc2c_rsp_if interfaces and the cipher top level.
module rc2_style_128bit_block_cipher_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0]  CMD_UNUSED    = 2'd3;
  localparam int unsigned QUIET_LIMIT   = 20000;
  localparam int unsigned DRAIN_CYCLES  = 700;
  localparam int unsigned HOLD_CYCLES   = 3000;
  localparam int unsigned PRINT_LIMIT   = 40;
  localparam int unsigned PHASE_ITEMS   = 130;

  typedef struct packed {
    logic [1:0]                  cmd;
    logic [rc2c_pkg::KEY_AW-1:0] key_index;
    rc2c_pkg::word_t             key_word;
    rc2c_pkg::word_t             w0;
    rc2c_pkg::word_t             w1;
    rc2c_pkg::word_t             w2;
    rc2c_pkg::word_t             w3;
  } cipher_req_t;

  typedef struct packed {
    rc2c_pkg::word_t w0;
    rc2c_pkg::word_t w1;
    rc2c_pkg::word_t w2;
    rc2c_pkg::word_t w3;
    logic            dec;
  } block_result_t;

  logic clk_i;
  logic rst_ni;

  rc2c_req_if req_bus ();
  rc2c_rsp_if rsp_bus ();

  rc2_style_128bit_block_cipher dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_bus),
    .rsp_o  (rsp_bus)
  );

  rc2c_pkg::word_t key_shadow [rc2c_pkg::SUBKEY_COUNT];
  block_result_t   expected_blocks [$];
  int unsigned     mismatch_count;
  int unsigned     send_idle_pct;
  int unsigned     recv_stall_pct;
  int unsigned     hold_request;
  int unsigned     quiet_cycles;

  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  function automatic rc2c_pkg::word_t rot_left(rc2c_pkg::word_t v, int unsigned s);
    return (v << s) | (v >> (rc2c_pkg::WORD_W - s));
  endfunction

  function automatic rc2c_pkg::word_t rot_right(rc2c_pkg::word_t v, int unsigned s);
    return (v >> s) | (v << (rc2c_pkg::WORD_W - s));
  endfunction

  // Runs the whole 64-round cipher on the shadow subkey table.
  function automatic block_result_t cipher_predict(cipher_req_t rq);
    rc2c_pkg::word_t a, b, c, d;
    logic [7:0]      base;
    int              rnd;
    block_result_t   res;
    a = rq.w0;
    b = rq.w1;
    c = rq.w2;
    d = rq.w3;
    if (rq.cmd == rc2c_pkg::CMD_ENC) begin
      for (int r = 0; r < rc2c_pkg::ROUND_COUNT; r++) begin
        base = 8'(r * 4);
        a = rot_left(a + (b & ~d) + (c & d) + key_shadow[base], 1);
        b = rot_left(b + (c & ~a) + (d & a) + key_shadow[base + 8'd1], 2);
        c = rot_left(c + (d & ~b) + (a & b) + key_shadow[base + 8'd2], 3);
        d = rot_left(d + (a & ~c) + (b & c) + key_shadow[base + 8'd3], 5);
        if (r % 6 == 4) begin
          a = a + key_shadow[d[7:0]];
          b = b + key_shadow[a[7:0]];
          c = c + key_shadow[b[7:0]];
          d = d + key_shadow[c[7:0]];
        end
      end
    end else begin
      for (int k = 0; k < rc2c_pkg::ROUND_COUNT; k++) begin
        rnd  = rc2c_pkg::ROUND_COUNT - 1 - k;
        base = 8'(rnd * 4);
        d = rot_right(d, 5) - ((a & ~c) + (b & c) + key_shadow[base + 8'd3]);
        c = rot_right(c, 3) - ((d & ~b) + (a & b) + key_shadow[base + 8'd2]);
        b = rot_right(b, 2) - ((c & ~a) + (d & a) + key_shadow[base + 8'd1]);
        a = rot_right(a, 1) - ((b & ~d) + (c & d) + key_shadow[base]);
        if (rnd % 6 == 5) begin
          d = d - key_shadow[c[7:0]];
          c = c - key_shadow[b[7:0]];
          b = b - key_shadow[a[7:0]];
          a = a - key_shadow[d[7:0]];
        end
      end
    end
    res.w0  = a;
    res.w1  = b;
    res.w2  = c;
    res.w3  = d;
    res.dec = (rq.cmd == rc2c_pkg::CMD_DEC);
    return res;
  endfunction

  // Mostly uniform words, with the all-zero and all-one corners now and then.
  function automatic rc2c_pkg::word_t rand_word();
    int unsigned pick;
    pick = $urandom_range(0, 15);
    if (pick == 0) return '0;
    if (pick == 1) return '1;
    return $urandom;
  endfunction

  function automatic cipher_req_t random_req(logic [1:0] cmd);
    cipher_req_t rq;
    rq.cmd       = cmd;
    rq.key_index = rc2c_pkg::KEY_AW'($urandom_range(0, rc2c_pkg::SUBKEY_COUNT - 1));
    rq.key_word  = rand_word();
    rq.w0        = rand_word();
    rq.w1        = rand_word();
    rq.w2        = rand_word();
    rq.w3        = rand_word();
    return rq;
  endfunction

  function automatic cipher_req_t build_req(logic [1:0] cmd, logic [7:0] idx,
                                            rc2c_pkg::word_t kw,
                                            rc2c_pkg::word_t w0, rc2c_pkg::word_t w1,
                                            rc2c_pkg::word_t w2, rc2c_pkg::word_t w3);
    cipher_req_t rq;
    rq.cmd       = cmd;
    rq.key_index = idx;
    rq.key_word  = kw;
    rq.w0        = w0;
    rq.w1        = w1;
    rq.w2        = w2;
    rq.w3        = w3;
    return rq;
  endfunction

  task automatic report_mismatch(string what, rc2c_pkg::word_t got, rc2c_pkg::word_t exp);
    if (mismatch_count < PRINT_LIMIT)
      $display("%0t ns: %s: got %08h, expected %08h", $realtime, what, got, exp);
    mismatch_count++;
  endtask

  // Offers one request, waits for it to be taken and updates the model on acceptance.
  task automatic send_request(input cipher_req_t rq, output block_result_t pred);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_bus.valid       <= 1'b1;
    req_bus.cmd         <= rq.cmd;
    req_bus.key_index   <= rq.key_index;
    req_bus.key_word    <= rq.key_word;
    req_bus.block_word0 <= rq.w0;
    req_bus.block_word1 <= rq.w1;
    req_bus.block_word2 <= rq.w2;
    req_bus.block_word3 <= rq.w3;
    do @(posedge clk_i); while (!req_bus.ready);
    pred = '0;
    if (rq.cmd == rc2c_pkg::CMD_LOAD) begin
      key_shadow[rq.key_index] = rq.key_word;
    end else if (rq.cmd != CMD_UNUSED) begin
      pred = cipher_predict(rq);
      expected_blocks.push_back(pred);
    end
  endtask

  // The rounds together read every entry, so the whole table is written before any block.
  task automatic fill_key_table();
    block_result_t pred;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    for (int i = 0; i < rc2c_pkg::SUBKEY_COUNT; i++)
      send_request(build_req(rc2c_pkg::CMD_LOAD, 8'(i), rand_word(), $urandom, $urandom,
                             $urandom, $urandom), pred);
    req_bus.valid <= 1'b0;
  endtask

  task automatic test_directed_corners();
    block_result_t pred;
    block_result_t cipher;
    cipher_req_t   pattern;
    pattern = build_req(rc2c_pkg::CMD_ENC, 8'd0, '0, 32'h8000_0000, 32'h0000_0001,
                        32'h5555_5555, 32'haaaa_aaaa);
    send_request(build_req(rc2c_pkg::CMD_LOAD, 8'd0, '0, '0, '0, '0, '0), pred);
    send_request(build_req(rc2c_pkg::CMD_LOAD, 8'd255, '1, '1, '1, '1, '1), pred);
    send_request(build_req(rc2c_pkg::CMD_ENC, 8'd0, '0, '0, '0, '0, '0), pred);
    send_request(build_req(rc2c_pkg::CMD_ENC, 8'd255, '1, '1, '1, '1, '1), pred);
    send_request(build_req(rc2c_pkg::CMD_DEC, 8'd0, '0, '0, '0, '0, '0), pred);
    send_request(build_req(rc2c_pkg::CMD_DEC, 8'd255, '1, '1, '1, '1, '1), pred);
    send_request(pattern, cipher);
    // Decrypting the fresh ciphertext must give the pattern back.
    send_request(build_req(rc2c_pkg::CMD_DEC, 8'd0, '0, cipher.w0, cipher.w1, cipher.w2,
                           cipher.w3), pred);
    // The unused command must leave the table alone: the pattern encrypts the same.
    send_request(build_req(CMD_UNUSED, 8'd255, '1, '1, '1, '1, '1), pred);
    send_request(pattern, pred);
    send_request(build_req(rc2c_pkg::CMD_LOAD, 8'd128, 32'ha5a5_a5a5, '0, '0, '0, '0), pred);
    send_request(build_req(rc2c_pkg::CMD_LOAD, 8'd128, 32'h5a5a_5a5a, '0, '0, '0, '0), pred);
    send_request(pattern, pred);
    send_request(build_req(rc2c_pkg::CMD_LOAD, 8'd0, '1, '0, '0, '0, '0), pred);
    send_request(build_req(rc2c_pkg::CMD_LOAD, 8'd255, '0, '0, '0, '0, '0), pred);
    send_request(build_req(rc2c_pkg::CMD_DEC, 8'd0, '0, '1, '1, '1, '1), pred);
    send_request(build_req(rc2c_pkg::CMD_ENC, 8'd0, '0, 32'h0000_00ff, 32'hffff_ff00,
                           32'h0000_0000, 32'hffff_ffff), pred);
    req_bus.valid <= 1'b0;
  endtask

  task automatic test_random_traffic(int unsigned send_pct, int unsigned recv_pct,
                                     int unsigned n_items);
    int unsigned   sent;
    int unsigned   pick;
    int unsigned   burst;
    cipher_req_t   rq;
    block_result_t pred;
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    sent           = 0;
    while (sent < n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 4) begin
        send_request(random_req(CMD_UNUSED), pred);
      end else if (pick < 35) begin
        // A burst of rekeying between blocks.
        burst = $urandom_range(1, 4);
        repeat (burst) begin
          send_request(random_req(rc2c_pkg::CMD_LOAD), pred);
          sent++;
        end
      end else if (pick < 60) begin
        send_request(random_req(rc2c_pkg::CMD_ENC), pred);
        rq    = random_req(rc2c_pkg::CMD_DEC);
        rq.w0 = pred.w0;
        rq.w1 = pred.w1;
        rq.w2 = pred.w2;
        rq.w3 = pred.w3;
        send_request(rq, pred);
        sent += 2;
      end else begin
        send_request(random_req($urandom_range(0, 1) ? rc2c_pkg::CMD_ENC
                                                     : rc2c_pkg::CMD_DEC), pred);
        sent++;
      end
    end
    req_bus.valid <= 1'b0;
  endtask

  // The receiver holds off long enough for a second block to finish behind the
  // waiting result, so the request side has to stall.
  task automatic test_output_backpressure();
    block_result_t pred;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_request   = HOLD_CYCLES;
    repeat (4) send_request(random_req(rc2c_pkg::CMD_ENC), pred);
    send_request(random_req(rc2c_pkg::CMD_LOAD), pred);
    send_request(random_req(rc2c_pkg::CMD_DEC), pred);
    req_bus.valid <= 1'b0;
  endtask

  initial begin : receiver
    int unsigned hold_left;
    hold_left     = 0;
    rsp_bus.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_request != 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left != 0) begin
        hold_left--;
        rsp_bus.ready <= 1'b0;
      end else begin
        rsp_bus.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin : result_check
    block_result_t exp;
    if (rst_ni && rsp_bus.valid && rsp_bus.ready) begin
      if (expected_blocks.size() == 0) begin
        report_mismatch("result with no block pending", rsp_bus.out_word0, '0);
      end else begin
        exp = expected_blocks.pop_front();
        if (rsp_bus.out_word0 !== exp.w0) report_mismatch("out_word0", rsp_bus.out_word0, exp.w0);
        if (rsp_bus.out_word1 !== exp.w1) report_mismatch("out_word1", rsp_bus.out_word1, exp.w1);
        if (rsp_bus.out_word2 !== exp.w2) report_mismatch("out_word2", rsp_bus.out_word2, exp.w2);
        if (rsp_bus.out_word3 !== exp.w3) report_mismatch("out_word3", rsp_bus.out_word3, exp.w3);
        if (rsp_bus.was_decrypt !== exp.dec)
          report_mismatch("was_decrypt", rc2c_pkg::word_t'(rsp_bus.was_decrypt),
                          rc2c_pkg::word_t'(exp.dec));
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    if (rst_ni) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t ns: no request or result moved for %0d cycles", $realtime, QUIET_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin
    mismatch_count      = 0;
    quiet_cycles        = 0;
    hold_request        = 0;
    send_idle_pct       = 0;
    recv_stall_pct      = 0;
    rst_ni              = 1'b0;
    req_bus.valid       = 1'b0;
    req_bus.cmd         = rc2c_pkg::CMD_LOAD;
    req_bus.key_index   = '0;
    req_bus.key_word    = '0;
    req_bus.block_word0 = '0;
    req_bus.block_word1 = '0;
    req_bus.block_word2 = '0;
    req_bus.block_word3 = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    fill_key_table();
    test_directed_corners();
    test_random_traffic(0, 0, PHASE_ITEMS);
    test_random_traffic(61, 0, PHASE_ITEMS);
    test_output_backpressure();
    test_random_traffic(0, 61, PHASE_ITEMS);
    test_random_traffic(13, 13, PHASE_ITEMS);

    recv_stall_pct = 0;
    while (expected_blocks.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatch_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
